/* rtl/core/mcop_pkg.sv */
// Shared types, constants and the exp table generator for the option pricer.
// Used by every module in rtl/core except mcop_checker; depends on nothing.
package mcop_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int EXP_ENTRIES_DEF = 256;
    localparam int SAMPLE_FRAC     = 12;
    localparam int X_W             = 40;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [31:0] PRICE_MAX    = 32'hFFFF_FFFF;
    localparam logic [19:0] RECIP6       = 20'd699051;
    localparam int          RECIP6_SHIFT = 22;

    typedef enum logic [2:0] {
        CFG_SPOT      = 3'd0,
        CFG_STRIKE    = 3'd1,
        CFG_DRIFT     = 3'd2,
        CFG_DIFFUSION = 3'd3,
        CFG_SCALE     = 3'd4,
        CFG_COUNT     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_HIGH   = 2'd1,
        CLS_LOW    = 2'd2
    } path_class_t;

    typedef struct packed {
        path_class_t             cls;
        logic signed [X_W-1:0]   x;
    } path_item_t;

    typedef struct packed {
        logic [31:0] spot;
        logic [31:0] strike;
        logic [31:0] drift;
        logic [31:0] diffusion;
        logic [63:0] scale;
        logic [31:0] count;
    } pricer_cfg_t;

    // 2^(idx/2^log_entries) in Q2.30 by a 15-term Taylor series
    function automatic logic [31:0] exp_entry(int unsigned idx, int unsigned log_entries);
        logic [63:0] w;
        logic [63:0] term;
        logic [63:0] sum;
        w    = (64'(idx) * 64'(LN2_Q30)) >> log_entries;
        term = 64'(ONE_Q30);
        sum  = 64'(ONE_Q30);
        for (int k = 1; k <= 14; k++) begin
            term = ((term * w) >> 30) / 64'(k);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

/* rtl/core/mcop_front.sv */
// Front end: takes samples, forms the exponent argument and classifies it.
// Depends on mcop_pkg.
module mcop_front #(
    parameter int FRAC_BITS = mcop_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   normal_sample,
    input  logic [31:0]          drift,
    input  logic [31:0]          diffusion,
    output logic                 push,
    output mcop_pkg::path_item_t push_item,
    input  logic                 full
);
    import mcop_pkg::*;

    localparam logic signed [X_W-1:0] LIM = X_W'(32) <<< FRAC_BITS;

    logic                stage_valid_reg, stage_valid_next;
    logic signed [15:0]  sample_reg;
    logic signed [48:0]  prod_w;
    logic signed [X_W-1:0] x_w;

    assign push     = stage_valid_reg && !full;
    assign in_ready = !stage_valid_reg || !full;

    assign prod_w = $signed({17'b0, diffusion}) * 49'(sample_reg);
    assign x_w    = X_W'(prod_w >>> SAMPLE_FRAC) + X_W'($signed(drift));

    always_comb
    begin
        push_item.x = x_w;
        priority if (x_w > LIM)
            push_item.cls = CLS_HIGH;
        else if (x_w < -LIM)
            push_item.cls = CLS_LOW;
        else
            push_item.cls = CLS_NORMAL;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            sample_reg <= normal_sample;
    end

endmodule

/* rtl/core/mcop_queue.sv */
// Short queue of classified paths between front and back end.
// Depends on mcop_pkg.
module mcop_queue #(
    parameter int DEPTH = mcop_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mcop_pkg::path_item_t wr_item,
    input  logic                 pop,
    output mcop_pkg::path_item_t rd_item,
    output logic                 full,
    output logic                 empty
);
    import mcop_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    path_item_t      slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

/* rtl/core/mcop_back.sv */
// Back end: exp evaluation, payoff sums and scaled result output.
// Depends on mcop_pkg.
module mcop_back #(
    parameter int FRAC_BITS         = mcop_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = mcop_pkg::EXP_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mcop_pkg::pricer_cfg_t cfg,
    input  logic                  empty,
    input  mcop_pkg::path_item_t  rd_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           call_price,
    output logic [31:0]           put_price
);
    import mcop_pkg::*;

    localparam int LOGE = $clog2(EXP_TABLE_ENTRIES);
    localparam int Y_W  = FRAC_BITS + 8;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LOG   = 12'b0000_0000_0010,
        S_FRAC  = 12'b0000_0000_0100,
        S_SQ    = 12'b0000_0000_1000,
        S_CUBE  = 12'b0000_0001_0000,
        S_POLY  = 12'b0000_0010_0000,
        S_MANT  = 12'b0000_0100_0000,
        S_SCALE = 12'b0000_1000_0000,
        S_PRICE = 12'b0001_0000_0000,
        S_ACC   = 12'b0010_0000_0000,
        S_MUL   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } back_state_t;

    logic [31:0] exp_tab [EXP_TABLE_ENTRIES];

    for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++)
    begin : g_tab
        assign exp_tab[g] = exp_entry(g, LOGE);
    end

    back_state_t state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] call_sum_reg, call_sum_next;
    logic [63:0] put_sum_reg, put_sum_next;
    logic [31:0] paths_reg, paths_next;
    logic        out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [X_W-1:0] x_reg;
    logic signed [Y_W-1:0] y_reg;
    logic signed [7:0]     n_reg;
    logic [29:0]           z_reg;
    logic [29:0]           z2_reg;
    logic [20:0]           z3_reg;
    logic [30:0]           p_reg;
    logic [31:0]           tab_reg;
    logic [30:0]           m_reg;
    logic [62:0]           prod_reg;
    logic [31:0]           st_reg;
    logic [63:0]           op_call_reg, op_put_reg;
    logic [127:0]          acc_call_reg, acc_put_reg;
    logic [31:0]           call_price_reg, put_price_reg;

    logic signed [FRAC_BITS+6:0]  x_narrow_w;
    logic signed [FRAC_BITS+38:0] ylog_w;
    logic [FRAC_BITS-1:0]         frac_w;
    logic [FRAC_BITS+LOGE-1:0]    scaled_w;
    logic [LOGE-1:0]              idx_w;
    logic [FRAC_BITS-1:0]         t_w;
    logic [FRAC_BITS+29:0]        tz_w;
    logic [40:0]                  div6_w;
    logic signed [7:0]            shift_w;
    logic [5:0]                   lshift_w;
    logic [62:0]                  rsh_w;
    logic [31:0]                  price_w;
    logic [31:0]                  sat_price_w;
    logic [31:0]                  call_pay_w, put_pay_w;
    logic [64:0]                  call_add_w, put_add_w;
    logic [31:0]                  target_w;
    logic [31:0]                  a_call_w, a_put_w, b_w;
    logic [6:0]                   pp_shift_w;
    logic [127:0]                 pp_call_w, pp_put_w;
    logic                         load_out;

    assign pop        = (state_reg == S_IDLE) && !empty;
    assign out_valid  = out_valid_reg;
    assign call_price = call_price_reg;
    assign put_price  = put_price_reg;

    assign x_narrow_w = $signed(x_reg[FRAC_BITS+6:0]);
    assign ylog_w     = (FRAC_BITS+39)'(x_narrow_w) *
                        (FRAC_BITS+39)'($signed({1'b0, LOG2E_Q30}));

    assign frac_w   = y_reg[FRAC_BITS-1:0];
    assign scaled_w = {frac_w, {LOGE{1'b0}}};
    assign idx_w    = scaled_w[FRAC_BITS+LOGE-1:FRAC_BITS];
    assign t_w      = scaled_w[FRAC_BITS-1:0];
    assign tz_w     = (FRAC_BITS+30)'(t_w) * (FRAC_BITS+30)'(LN2_Q30);
    assign div6_w   = (41'(z3_reg) * 41'(RECIP6)) >> RECIP6_SHIFT;

    // price = prod * 2^(n - 30), saturated to 32 bits
    assign shift_w  = 8'sd30 - n_reg;
    assign lshift_w = 6'(-shift_w);
    assign rsh_w    = prod_reg >> shift_w[5:0];

    always_comb
    begin
        priority if (shift_w >= 8'sd64)
            price_w = '0;
        else if (shift_w > 8'sd0)
            price_w = (rsh_w[62:32] != '0) ? PRICE_MAX : rsh_w[31:0];
        else if (lshift_w >= 6'd32)
            price_w = (prod_reg != '0) ? PRICE_MAX : '0;
        else if ((prod_reg >> (6'd32 - lshift_w)) != '0)
            price_w = PRICE_MAX;
        else
            price_w = 32'(prod_reg << lshift_w);
    end

    assign sat_price_w = (rd_item.cls == CLS_HIGH && cfg.spot != '0) ? PRICE_MAX : '0;

    assign call_pay_w = (st_reg > cfg.strike) ? st_reg - cfg.strike : '0;
    assign put_pay_w  = (cfg.strike > st_reg) ? cfg.strike - st_reg : '0;
    assign call_add_w = 65'(call_sum_reg) + 65'(call_pay_w);
    assign put_add_w  = 65'(put_sum_reg) + 65'(put_pay_w);
    assign target_w   = (cfg.count == '0) ? 32'd1 : cfg.count;

    // one 32x32 partial product per lane and step
    assign a_call_w   = step_reg[0] ? op_call_reg[63:32] : op_call_reg[31:0];
    assign a_put_w    = step_reg[0] ? op_put_reg[63:32] : op_put_reg[31:0];
    assign b_w        = step_reg[1] ? cfg.scale[63:32] : cfg.scale[31:0];
    assign pp_shift_w = {step_reg[0] & step_reg[1], step_reg[0] ^ step_reg[1], 5'b0};
    assign pp_call_w  = (128'(a_call_w) * 128'(b_w)) << pp_shift_w;
    assign pp_put_w   = (128'(a_put_w) * 128'(b_w)) << pp_shift_w;

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        call_sum_next  = call_sum_reg;
        put_sum_next   = put_sum_reg;
        paths_next     = paths_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
                if (!empty)
                    state_next = (rd_item.cls == CLS_NORMAL) ? S_LOG : S_ACC;
            S_LOG:   state_next = S_FRAC;
            S_FRAC:  state_next = S_SQ;
            S_SQ:    state_next = S_CUBE;
            S_CUBE:  state_next = S_POLY;
            S_POLY:  state_next = S_MANT;
            S_MANT:  state_next = S_SCALE;
            S_SCALE: state_next = S_PRICE;
            S_PRICE: state_next = S_ACC;
            S_ACC:
            begin
                call_sum_next = call_add_w[64] ? '1 : call_add_w[63:0];
                put_sum_next  = put_add_w[64] ? '1 : put_add_w[63:0];
                paths_next    = paths_reg + 32'd1;
                state_next    = S_IDLE;
                if (paths_next >= target_w)
                begin
                    call_sum_next = '0;
                    put_sum_next  = '0;
                    paths_next    = '0;
                    step_next     = '0;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = S_OUT;
            end
            S_OUT:
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            call_sum_reg  <= '0;
            put_sum_reg   <= '0;
            paths_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            call_sum_reg  <= call_sum_next;
            put_sum_reg   <= put_sum_next;
            paths_reg     <= paths_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg  <= rd_item.x;
            st_reg <= sat_price_w;
        end
        if (state_reg == S_LOG)
            y_reg <= Y_W'(ylog_w >>> 30);
        if (state_reg == S_FRAC)
        begin
            n_reg   <= 8'(y_reg >>> FRAC_BITS);
            z_reg   <= 30'(tz_w >> (LOGE + FRAC_BITS));
            tab_reg <= exp_tab[idx_w];
        end
        if (state_reg == S_SQ)
            z2_reg <= 30'((60'(z_reg) * 60'(z_reg)) >> 30);
        if (state_reg == S_CUBE)
            z3_reg <= 21'((60'(z2_reg) * 60'(z_reg)) >> 30);
        if (state_reg == S_POLY)
            p_reg <= ONE_Q30 + 31'(z_reg) + 31'(z2_reg >> 1) + 31'(div6_w);
        if (state_reg == S_MANT)
            m_reg <= 31'((63'(tab_reg) * 63'(p_reg)) >> 30);
        if (state_reg == S_SCALE)
            prod_reg <= 63'(cfg.spot) * 63'(m_reg);
        if (state_reg == S_PRICE)
            st_reg <= price_w;
        if (state_reg == S_ACC)
        begin
            op_call_reg  <= call_add_w[64] ? '1 : call_add_w[63:0];
            op_put_reg   <= put_add_w[64] ? '1 : put_add_w[63:0];
            acc_call_reg <= '0;
            acc_put_reg  <= '0;
        end
        if (state_reg == S_MUL)
        begin
            acc_call_reg <= acc_call_reg + pp_call_w;
            acc_put_reg  <= acc_put_reg + pp_put_w;
        end
        if (load_out)
        begin
            call_price_reg <= (acc_call_reg[127:96] != '0) ? PRICE_MAX : acc_call_reg[95:64];
            put_price_reg  <= (acc_put_reg[127:96] != '0) ? PRICE_MAX : acc_put_reg[95:64];
        end
    end

endmodule

/* rtl/core/monte_carlo_option_pricer.sv */
// Top level of the Monte Carlo European option pricer.
// Depends on mcop_pkg, mcop_front, mcop_queue and mcop_back.
//
// Usage:
//   Input channel (in_valid/in_ready/normal_sample): one standard normal draw
//   per transfer, signed Q4.12. Each draw is one simulated path.
//   Output channel (out_valid/out_ready/call_price/put_price): one transfer
//   after every path_count paths, carrying the discounted mean payoffs.
//   Configuration: write cfg_data into register cfg_index while cfg_wr_en is
//   high; indexes past the last register are ignored. Write only when idle.
// Flow:
//   A draw passes one front register into a four-entry queue. The back end
//   sequencer steps each path through IDLE, LOG, FRAC, SQ, CUBE, POLY, MANT,
//   SCALE, PRICE, ACC (IDLE, ACC alone when the exponent saturates), at most
//   one multiply per state; it pops a path only in IDLE. A batch's last path
//   adds MUL (64x64 scaling, four 32x32 partial products), OUT (output load).
// Reset clears the sums, the path counter, the queue and the output valid,
//   and restores the register defaults. While the receiver stalls, the
//   result holds in the output register; the back end keeps consuming paths
//   until the next batch result is ready, and the queue then fills and drops
//   in_ready.
module monte_carlo_option_pricer #(
    parameter int FRAC_BITS         = mcop_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = mcop_pkg::EXP_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] normal_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        call_price,
    output logic [31:0]        put_price
);
    import mcop_pkg::*;

    pricer_cfg_t cfg_reg, cfg_next;
    logic        push, pop, full, empty;
    path_item_t  push_item, rd_item;

    // register file: hold until written
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SPOT:      cfg_next.spot      = cfg_data[31:0];
                CFG_STRIKE:    cfg_next.strike    = cfg_data[31:0];
                CFG_DRIFT:     cfg_next.drift     = cfg_data[31:0];
                CFG_DIFFUSION: cfg_next.diffusion = cfg_data[31:0];
                CFG_SCALE:     cfg_next.scale     = cfg_data;
                CFG_COUNT:     cfg_next.count     = cfg_data[31:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spot      <= 32'd6553600;
            cfg_reg.strike    <= 32'd6684672;
            cfg_reg.drift     <= 32'hFFFF_FC8A;
            cfg_reg.diffusion <= 32'd15719;
            cfg_reg.scale     <= 64'd181680000000;
            cfg_reg.count     <= 32'd100000000;
        end
        else
            cfg_reg <= cfg_next;
    end

    // front: classify each draw by its exponent range
    mcop_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .normal_sample (normal_sample),
        .drift         (cfg_reg.drift),
        .diffusion     (cfg_reg.diffusion),
        .push          (push),
        .push_item     (push_item),
        .full          (full)
    );

    mcop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (rd_item),
        .full    (full),
        .empty   (empty)
    );

    // back: price, accumulate, scale and emit
    mcop_back #(
        .FRAC_BITS         (FRAC_BITS),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .empty      (empty),
        .rd_item    (rd_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .call_price (call_price),
        .put_price  (put_price)
    );

endmodule

/* rtl/core/mcop_checker.sv */
// Port-level checks for the option pricer, bound to the top level.
// Depends on monte_carlo_option_pricer ports only.
module mcop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_index,
    input logic [63:0] cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] normal_sample,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] call_price,
    input logic [31:0] put_price
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(call_price) && $stable(put_price))
        else $error("result changed while stalled");

    // reset drops the output and opens the input
    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("bad state in reset");

    // handshake outputs are always driven to known levels
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("unknown handshake output");

    // a waiting draw holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(normal_sample))
        else $error("draw changed while waiting");

    // register writes carry known index and data
    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !$isunknown({cfg_index, cfg_data}))
        else $error("unknown register write");

endmodule

bind monte_carlo_option_pricer mcop_checker u_mcop_checker (.*);
